// ===== hdl/fwntp_pkg.sv =====
// ----------------------------------------------------------------------------
// fwntp_pkg: shared types and constants of the number to text placer
// Field widths, operation codes, character codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fwntp_pkg;

  localparam int VALUE_W    = 32;
  localparam int OP_W       = 3;
  localparam int CNT_W      = 6;
  localparam int LINE_W     = 4;
  localparam int SCOL_W     = 5;
  localparam int OUT_LINE_W = 3;
  localparam int OUT_COL_W  = 5;
  localparam int GLYPH_W    = 7;
  // Running column: start column plus sign, digits, point and fraction.
  localparam int COL_W      = 7;
  localparam int DEC_DIGITS = 10;
  localparam int DIG_IDX_W  = 4;
  localparam int RESULT_LIMIT = 16;

  localparam logic [OP_W-1:0] OP_UDEC  = 3'd0;
  localparam logic [OP_W-1:0] OP_SDEC  = 3'd1;
  localparam logic [OP_W-1:0] OP_HEX   = 3'd2;
  localparam logic [OP_W-1:0] OP_BIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIXED = 3'd4;

  localparam logic [GLYPH_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [GLYPH_W-1:0] CH_A     = 7'h41;
  localparam logic [GLYPH_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [GLYPH_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [GLYPH_W-1:0] CH_POINT = 7'h2E;

  // floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v.
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DIGIT = 2'd0;
  localparam kind_t KIND_SIGN  = 2'd1;
  localparam kind_t KIND_POINT = 2'd2;

  typedef logic [1:0] base_t;
  localparam base_t BASE_DEC = 2'd0;
  localparam base_t BASE_HEX = 2'd1;
  localparam base_t BASE_BIN = 2'd2;

  typedef struct packed {
    logic                  load;
    logic                  negate;
    logic                  low_half;
    logic                  mul;
    logic                  div;
    logic                  emit;
    kind_t                 kind;
    base_t                 base;
    logic                  int_part;
    logic [CNT_W-1:0]      pos;
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  col;
    logic                  last;
  } dp_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/fwntp_dp.sv =====
// ----------------------------------------------------------------------------
// fwntp_dp: datapath of the number to text placer
// Holds the number, converts it to decimal digits with a shared divide-by-ten
// unit, selects the glyph of each character and drives the output register.
// ----------------------------------------------------------------------------
module fwntp_dp import fwntp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [VALUE_W-1:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_LINE_W-1:0] out_line,
  output logic [OUT_COL_W-1:0]  out_column,
  output logic [GLYPH_W-1:0]    out_glyph_code,
  output logic                  out_final_char
);

  localparam int QUOT_W = 2 * VALUE_W - RECIP_SHIFT;

  logic [VALUE_W-1:0]    val_r;
  logic [VALUE_W-1:0]    work_r;
  logic [2*VALUE_W-1:0]  prod_r;
  logic [3:0]            digit_r [DEC_DIGITS];
  logic [DIG_IDX_W-1:0]  idx_r;
  logic                  out_valid_r;
  logic [OUT_LINE_W-1:0] out_line_r;
  logic [OUT_COL_W-1:0]  out_col_r;
  logic [GLYPH_W-1:0]    glyph_r;
  logic                  final_r;

  logic [QUOT_W-1:0]     quot;
  logic [VALUE_W-1:0]    rem;
  logic [2*VALUE_W-1:0]  prod_nxt;
  logic [CNT_W-1:0]      dec_pos;
  logic [3:0]            digit;
  logic [GLYPH_W-1:0]    glyph;

  assign quot     = prod_r[2*VALUE_W-1:RECIP_SHIFT];
  assign rem      = work_r - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign prod_nxt = {{VALUE_W{1'b0}}, work_r} * {{VALUE_W{1'b0}}, RECIP_10};

  // In fixed point mode the integer part is the number divided by 100, so its
  // digits sit two places higher in the decimal digit buffer.
  assign dec_pos = cmd.int_part ? cmd.pos + CNT_W'(2) : cmd.pos;

  always_comb begin
    digit = 4'd0;
    case (cmd.base)
      BASE_HEX: begin
        if (cmd.pos < CNT_W'(8)) digit = val_r[{cmd.pos[2:0], 2'b00} +: 4];
      end
      BASE_BIN: begin
        if (cmd.pos < CNT_W'(VALUE_W)) digit = {3'b000, val_r[cmd.pos[4:0]]};
      end
      default: begin
        // Positions beyond the converted digits are leading zeros.
        if (dec_pos < CNT_W'(idx_r)) digit = digit_r[dec_pos[DIG_IDX_W-1:0]];
      end
    endcase
  end

  always_comb begin
    case (cmd.kind)
      KIND_SIGN:  glyph = val_r[VALUE_W-1] ? CH_MINUS : CH_PLUS;
      KIND_POINT: glyph = CH_POINT;
      default: begin
        if (digit < 4'd10) glyph = CH_ZERO + {3'b000, digit};
        else               glyph = CH_A + {3'b000, digit} - 7'd10;
      end
    endcase
  end

  assign sts.quot_zero = (quot == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
      if (cmd.negate && in_value[VALUE_W-1]) work_r <= ~in_value + 32'd1;
      else if (cmd.low_half)                  work_r <= {16'h0000, in_value[15:0]};
      else                                    work_r <= in_value;
    end else if (cmd.div) begin
      work_r <= VALUE_W'(quot);
    end
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.div) digit_r[idx_r] <= rem[3:0];
    if (cmd.emit) begin
      out_line_r <= cmd.line;
      out_col_r  <= cmd.col;
      glyph_r    <= glyph;
      final_r    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load)     idx_r <= '0;
      else if (cmd.div) idx_r <= idx_r + DIG_IDX_W'(1);
      if (cmd.emit)           out_valid_r <= 1'b1;
      else if (!out_stall)    out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line       = out_line_r;
  assign out_column     = out_col_r;
  assign out_glyph_code = glyph_r;
  assign out_final_char = final_r;

endmodule

// ===== hdl/fwntp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwntp_ctrl: controller of the number to text placer
// Takes an item, finds the visible columns, runs the decimal modes' digit
// conversion and walks sign, digits, point and fraction one character a step.
// ----------------------------------------------------------------------------
module fwntp_ctrl import fwntp_pkg::*; #(
  parameter int TEXT_COLUMNS = 16,
  parameter int TEXT_LINES   = 4,
  parameter int MAX_DIGITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [CNT_W-1:0]  in_digit_count,
  input  logic [LINE_W-1:0] in_text_line,
  input  logic [SCOL_W-1:0] in_start_column,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_INT   = 3'd5;
  localparam logic [2:0] S_POINT = 3'd6;
  localparam logic [2:0] S_FRAC  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [CNT_W-1:0]  n_r;
  logic [LINE_W-1:0] line_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  last_r, last_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              in_acc;
  logic              is_dec;
  logic [COL_W-1:0]  total;
  logic [COL_W-1:0]  end_col;
  logic [COL_W-1:0]  first_col;
  logic [COL_W-1:0]  lim_col;
  logic              line_ok;
  logic              op_ok;
  logic              shown;
  logic              col_vis;
  logic              step;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign is_dec   = (op_r == OP_UDEC) || (op_r == OP_SDEC) || (op_r == OP_FIXED);

  // Visible columns form one run; its last column ends the item.
  always_comb begin
    total = COL_W'(n_r);
    if (op_r == OP_SDEC)  total = total + COL_W'(1);
    if (op_r == OP_FIXED) total = total + COL_W'(3);
    end_col   = col_r + total - COL_W'(1);
    first_col = (col_r == '0) ? COL_W'(1) : col_r;
    lim_col   = first_col + COL_W'(RESULT_LIMIT - 1);
    last_nxt  = end_col;
    if (COL_W'(TEXT_COLUMNS) < last_nxt) last_nxt = COL_W'(TEXT_COLUMNS);
    if (lim_col < last_nxt)              last_nxt = lim_col;
    line_ok = (line_r != '0) && ({1'b0, line_r} <= 5'(TEXT_LINES));
    op_ok   = (op_r <= OP_FIXED);
    shown   = line_ok && op_ok && (total != '0) && (first_col <= last_nxt);
  end

  assign col_vis = (col_r != '0);
  assign step    = !col_vis || sts.out_free;

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load     = in_acc;
    cmd.negate   = (in_op == OP_SDEC);
    cmd.low_half = (in_op == OP_FIXED);
    cmd.kind     = KIND_DIGIT;
    cmd.base     = (op_r == OP_HEX) ? BASE_HEX : ((op_r == OP_BIN) ? BASE_BIN : BASE_DEC);
    cmd.pos      = cnt_r - CNT_W'(1);
    cmd.line     = line_r[OUT_LINE_W-1:0];
    cmd.col      = col_r[OUT_COL_W-1:0];
    cmd.last     = (col_r == last_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cnt_nxt = n_r;
        if (!shown)      state_nxt = S_IDLE;
        else if (is_dec) state_nxt = S_MUL;
        else             state_nxt = S_INT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (!sts.quot_zero)       state_nxt = S_MUL;
        else if (op_r == OP_SDEC) state_nxt = S_SIGN;
        else                      state_nxt = S_INT;
      end
      S_SIGN: begin
        cmd.kind = KIND_SIGN;
        cmd.emit = col_vis && sts.out_free;
        if (step) begin
          col_nxt   = col_r + COL_W'(1);
          state_nxt = (cmd.emit && cmd.last) ? S_IDLE : S_INT;
        end
      end
      S_INT: begin
        cmd.int_part = (op_r == OP_FIXED);
        if (cnt_r == '0) begin
          state_nxt = (op_r == OP_FIXED) ? S_POINT : S_IDLE;
        end else begin
          cmd.emit = col_vis && sts.out_free;
          if (step) begin
            col_nxt = col_r + COL_W'(1);
            cnt_nxt = cnt_r - CNT_W'(1);
            if (cmd.emit && cmd.last) state_nxt = S_IDLE;
          end
        end
      end
      S_POINT: begin
        cmd.kind = KIND_POINT;
        cmd.emit = col_vis && sts.out_free;
        if (step) begin
          col_nxt   = col_r + COL_W'(1);
          cnt_nxt   = CNT_W'(2);
          state_nxt = (cmd.emit && cmd.last) ? S_IDLE : S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.base = BASE_DEC;
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.emit = col_vis && sts.out_free;
          if (step) begin
            col_nxt = col_r + COL_W'(1);
            cnt_nxt = cnt_r - CNT_W'(1);
            if (cmd.emit && cmd.last) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      n_r    <= (in_digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : in_digit_count;
      line_r <= in_text_line;
    end
    if (state_r == S_SETUP) last_r <= last_nxt;
    cnt_r <= cnt_nxt;
    if (in_acc) col_r <= COL_W'(in_start_column);
    else        col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_col_visible: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (col_r != '0) && (col_r <= COL_W'(TEXT_COLUMNS)))
    else $error("character emitted outside the visible columns");

  a_emit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("character emitted into an occupied output register");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("item continued after its last character");

  a_div_decimal_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (op_r == OP_UDEC || op_r == OP_SDEC || op_r == OP_FIXED))
    else $error("decimal conversion run for a non-decimal mode");

endmodule

// ===== hdl/fixed_width_number_to_text_placer.sv =====
// ----------------------------------------------------------------------------
// fixed_width_number_to_text_placer: formats a number as fixed-width text
// Emits one character item per visible grid cell, most significant first.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   op, value, digit_count,
//                                           text_line, start_column
//   out_     output     out_valid/out_stall line, column, glyph_code,
//                                           final_char
//
// An item is set up first, then each decimal digit of the converted number
// (up to ten, through one shared divide-by-ten unit) takes a multiply and a
// divide step, then the characters are placed one per step in column order.
// Reset is synchronous and clears the controller state and the output valid.
// A stalled output holds its character; the controller waits for it to leave.
// The next item is taken as soon as the last character is in the output
// register.
// ----------------------------------------------------------------------------
module fixed_width_number_to_text_placer import fwntp_pkg::*; #(
  parameter int TEXT_COLUMNS = 16,
  parameter int TEXT_LINES   = 4,
  parameter int MAX_DIGITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic [CNT_W-1:0]      in_digit_count,
  input  logic [LINE_W-1:0]     in_text_line,
  input  logic [SCOL_W-1:0]     in_start_column,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_LINE_W-1:0] out_line,
  output logic [OUT_COL_W-1:0]  out_column,
  output logic [GLYPH_W-1:0]    out_glyph_code,
  output logic                  out_final_char
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fwntp_ctrl #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_LINES  (TEXT_LINES),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_digit_count (in_digit_count),
    .in_text_line   (in_text_line),
    .in_start_column(in_start_column),
    .cmd            (cmd),
    .sts            (sts)
  );

  fwntp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line      (out_line),
    .out_column    (out_column),
    .out_glyph_code(out_glyph_code),
    .out_final_char(out_final_char)
  );

endmodule

// ===== tb/tb_fixed_width_number_to_text_placer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_width_number_to_text_placer: self-checking bench for the placer
// A directed set covers each format, the digit limits and the edges of the
// text grid. A random set then mixes mostly visible items with noise. Both
// handshakes idle in random bursts. Every character leaving the block is
// compared with a predicted character queue.
// ----------------------------------------------------------------------------
module tb_fixed_width_number_to_text_placer;
  import fwntp_pkg::*;

  localparam int TEXT_COLUMNS = 16;
  localparam int TEXT_LINES   = 4;
  localparam int MAX_DIGITS   = 32;
  localparam int NUM_RANDOM   = 255;
  localparam int QUIET_ITEMS  = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 100;

  // Operation codes that the block does not define.
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct {
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  column;
    logic [GLYPH_W-1:0]    glyph;
    logic                  last;
  } glyph_t;

  class glyph_tracker;
    glyph_t expected_glyphs[$];
    int     errors;
    int     checked;
    int     cur_col;
    int     emitted;
    logic [LINE_W-1:0] cur_line;

    function void place_char(logic [GLYPH_W-1:0] ch);
      glyph_t g;
      int c;
      c = cur_col;
      cur_col++;
      if (c == 0 || c > TEXT_COLUMNS) return;
      if (emitted >= RESULT_LIMIT) return;
      g.line   = cur_line[OUT_LINE_W-1:0];
      g.column = c[OUT_COL_W-1:0];
      g.glyph  = ch;
      g.last   = 1'b0;
      expected_glyphs.push_back(g);
      emitted++;
    endfunction

    // Digits most significant first; positions beyond 32 bits read as zero.
    function void place_digits(base_t base, logic [VALUE_W-1:0] v, int n);
      int pos;
      longint unsigned div;
      logic [VALUE_W-1:0] d;
      for (int i = 0; i < n; i++) begin
        pos = n - 1 - i;
        if (base == BASE_HEX) begin
          d = (pos >= 8) ? '0 : ((v >> (4 * pos)) & 32'hF);
        end else if (base == BASE_BIN) begin
          d = (pos >= 32) ? '0 : ((v >> pos) & 32'h1);
        end else if (pos >= DEC_DIGITS) begin
          d = '0;
        end else begin
          div = 1;
          for (int k = 0; k < pos; k++) div = div * 10;
          d = VALUE_W'((longint'(v) / div) % 10);
        end
        if (d < 10) place_char(CH_ZERO + GLYPH_W'(d));
        else place_char(CH_A + GLYPH_W'(d - 10));
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                            logic [CNT_W-1:0] cnt, logic [LINE_W-1:0] line,
                            logic [SCOL_W-1:0] col);
      int n;
      logic [VALUE_W-1:0] v16;
      glyph_t g;
      n = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
      if (line == 0 || line > TEXT_LINES) return;
      cur_line = line;
      cur_col  = int'(col);
      emitted  = 0;
      case (op)
        OP_UDEC: place_digits(BASE_DEC, value, n);
        OP_SDEC: begin
          if (value[VALUE_W-1]) begin
            place_char(CH_MINUS);
            place_digits(BASE_DEC, ~value + 32'd1, n);
          end else begin
            place_char(CH_PLUS);
            place_digits(BASE_DEC, value, n);
          end
        end
        OP_HEX: place_digits(BASE_HEX, value, n);
        OP_BIN: place_digits(BASE_BIN, value, n);
        OP_FIXED: begin
          v16 = value & 32'hFFFF;
          place_digits(BASE_DEC, v16 / 100, n);
          place_char(CH_POINT);
          place_digits(BASE_DEC, v16 % 100, 2);
        end
        default: ;
      endcase
      if (emitted > 0) begin
        g = expected_glyphs.pop_back();
        g.last = 1'b1;
        expected_glyphs.push_back(g);
      end
    endfunction

    function void check_char(logic [OUT_LINE_W-1:0] line, logic [OUT_COL_W-1:0] col,
                             logic [GLYPH_W-1:0] glyph, logic last);
      glyph_t g;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected character: line %0d column %0d glyph %0h", line, col, glyph);
        errors++;
        return;
      end
      g = expected_glyphs.pop_front();
      checked++;
      if (line !== g.line) begin
        $error("out_line: expected %0d, actual %0d", g.line, line);
        errors++;
      end
      if (col !== g.column) begin
        $error("out_column: expected %0d, actual %0d", g.column, col);
        errors++;
      end
      if (glyph !== g.glyph) begin
        $error("out_glyph_code: expected %0h, actual %0h", g.glyph, glyph);
        errors++;
      end
      if (last !== g.last) begin
        $error("out_final_char: expected %0b, actual %0b", g.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op;
  logic [VALUE_W-1:0]    in_value;
  logic [CNT_W-1:0]      in_digit_count;
  logic [LINE_W-1:0]     in_text_line;
  logic [SCOL_W-1:0]     in_start_column;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_LINE_W-1:0] out_line;
  logic [OUT_COL_W-1:0]  out_column;
  logic [GLYPH_W-1:0]    out_glyph_code;
  logic                  out_final_char;

  glyph_tracker tracker;
  int  items_sent;
  int  rx_hold_req;
  bit  rx_quiet;

  fixed_width_number_to_text_placer #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_LINES  (TEXT_LINES),
    .MAX_DIGITS  (MAX_DIGITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .in_text_line   (in_text_line),
    .in_start_column(in_start_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line       (out_line),
    .out_column     (out_column),
    .out_glyph_code (out_glyph_code),
    .out_final_char (out_final_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tracker.note_item(in_op, in_value, in_digit_count, in_text_line, in_start_column);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_char(out_line, out_column, out_glyph_code, out_final_char);
    end
  end

  // Receiver: random stall bursts, a requested long hold-off, or none at all.
  initial begin
    int  phase_left;
    bit  phase_stall;
    out_stall   = 1'b0;
    phase_left  = 0;
    phase_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        out_stall = 1'b1;
        rx_hold_req--;
      end else if (rx_quiet) begin
        out_stall = 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_stall = ($urandom_range(0, 2) == 0);
          phase_left  = phase_stall ? $urandom_range(1, 6) : $urandom_range(1, 30);
        end
        out_stall = phase_stall;
        phase_left--;
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on either side.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [CNT_W-1:0] cnt, input logic [LINE_W-1:0] line,
                           input logic [SCOL_W-1:0] col);
    @(negedge clk);
    in_valid        = 1'b1;
    in_op           = op;
    in_value        = value;
    in_digit_count  = cnt;
    in_text_line    = line;
    in_start_column = col;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_chars;
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_glyphs.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   cnt;
    logic [LINE_W-1:0]  line;
    logic [SCOL_W-1:0]  col;
    bit noise;
    noise = ($urandom_range(0, 6) == 0);
    op = noise ? OP_W'($urandom_range(0, 7)) : OP_W'($urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0: value = $urandom_range(0, 999);
      1: value = $urandom_range(0, 65535);
      2: begin
        case ($urandom_range(0, 3))
          0: value = 32'h0000_0000;
          1: value = 32'hFFFF_FFFF;
          2: value = 32'h8000_0000;
          default: value = 32'h7FFF_FFFF;
        endcase
      end
      default: value = $urandom;
    endcase
    if (noise) cnt = CNT_W'($urandom_range(0, 63));
    else if ($urandom_range(0, 9) == 0) cnt = CNT_W'($urandom_range(11, 32));
    else cnt = CNT_W'($urandom_range(1, 10));
    line = noise ? LINE_W'($urandom_range(0, 15)) : LINE_W'($urandom_range(1, 4));
    col  = noise ? SCOL_W'($urandom_range(0, 31)) : SCOL_W'($urandom_range(1, 12));
    send_item(op, value, cnt, line, col);
  endtask

  initial begin
    bit gaps_on;
    tracker         = new;
    items_sent      = 0;
    rx_hold_req     = 0;
    rx_quiet        = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_UDEC;
    in_value        = '0;
    in_digit_count  = '0;
    in_text_line    = '0;
    in_start_column = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: formats, digit limits, grid edges and undefined operations.
    send_item(OP_UDEC,  32'h0000_0000, 6'd10, 4'd1,  5'd1);
    send_item(OP_UDEC,  32'hFFFF_FFFF, 6'd12, 4'd2,  5'd1);
    send_item(OP_SDEC,  32'h8000_0000, 6'd10, 4'd3,  5'd1);
    send_item(OP_SDEC,  32'h7FFF_FFFF, 6'd10, 4'd4,  5'd2);
    send_item(OP_SDEC,  32'h0000_0000, 6'd3,  4'd1,  5'd5);
    send_item(OP_SDEC,  32'hFFFF_FFFF, 6'd4,  4'd2,  5'd3);
    send_item(OP_HEX,   32'hDEAD_BEEF, 6'd8,  4'd3,  5'd1);
    send_item(OP_HEX,   32'hFFFF_FFFF, 6'd11, 4'd4,  5'd4);
    send_item(OP_BIN,   32'hA5A5_A5A5, 6'd16, 4'd1,  5'd1);
    send_item(OP_BIN,   32'hFFFF_FFFF, 6'd32, 4'd2,  5'd1);
    send_item(OP_BIN,   32'h5555_5555, 6'd40, 4'd3,  5'd31);
    send_item(OP_FIXED, 32'h0000_FFFF, 6'd3,  4'd4,  5'd1);
    send_item(OP_FIXED, 32'h0001_2345, 6'd2,  4'd1,  5'd10);
    send_item(OP_FIXED, 32'h0000_0000, 6'd0,  4'd2,  5'd1);
    send_item(OP_UDEC,  32'd12345,     6'd0,  4'd3,  5'd1);
    send_item(OP_UDEC,  32'd987654321, 6'd63, 4'd4,  5'd1);
    send_item(OP_HEX,   32'h1234_5678, 6'd33, 4'd1,  5'd1);
    send_item(OP_UDEC,  32'd42,        6'd5,  4'd0,  5'd1);
    send_item(OP_UDEC,  32'd42,        6'd5,  4'd5,  5'd1);
    send_item(OP_HEX,   32'hCAFE_F00D, 6'd8,  4'd15, 5'd1);
    send_item(OP_UDEC,  32'd7531,      6'd4,  4'd1,  5'd0);
    send_item(OP_SDEC,  32'hFFFF_FF9C, 6'd3,  4'd2,  5'd16);
    send_item(OP_HEX,   32'hABCD_EF01, 6'd8,  4'd3,  5'd17);
    send_item(OP_RSVD_LO, 32'hFFFF_FFFF, 6'd10, 4'd1, 5'd1);
    send_item(OP_RSVD_HI, 32'h0000_0001, 6'd10, 4'd4, 5'd1);
    wait_all_chars();

    gaps_on = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      // The receiver holds off while items keep coming, so the input backs up.
      if (i == 60) rx_hold_req = HOLD_CYCLES;
      if (i == 140) wait_all_chars();
      if (i == NUM_RANDOM - QUIET_ITEMS) rx_quiet = 1'b1;
      if (gaps_on && !rx_quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 6));
      send_random_item();
    end

    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (tracker.expected_glyphs.size() != 0) @(posedge clk);

    $display("covered %0d items in all five formats plus undefined ops, %0d characters checked",
             items_sent, tracker.checked);
    $display("included grid edges, digit saturation, a long output hold-off and a full drain");
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== fixed_width_number_to_text_placer.f =====
hdl/fwntp_pkg.sv
hdl/fwntp_dp.sv
hdl/fwntp_ctrl.sv
hdl/fixed_width_number_to_text_placer.sv
tb/tb_fixed_width_number_to_text_placer.sv
